>>> rtl/pnn_pkg.sv
// ----------------------------------------------------------------------------
// pnn_pkg: shared constants and types for the periodic nearest-neighbour core
// Field widths, status and register codes, and the controller state type.
// ----------------------------------------------------------------------------
package pnn_pkg;

    localparam int MAX_REFS_DEF    = 1024;
    localparam int COORD_WIDTH_DEF = 20;

    localparam int ENTRY_W   = 20;   // one matrix entry
    localparam int ROW_W     = 3 * ENTRY_W;
    localparam int FRAC_W    = 24;   // Q8.16 fraction
    localparam int CFG_IDX_W = 3;
    localparam int SQ_W      = 58;   // squared norm, Q32
    localparam int DIST_W    = 21;
    localparam int INDEX_W   = 10;
    localparam int STATUS_W  = 3;

    localparam int FRAC_MAX = 2 ** (FRAC_W - 1) - 1;
    localparam int FRAC_MIN = -(2 ** (FRAC_W - 1));

    localparam logic [1:0] MODE_STORE = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_STORED   = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DROPPED  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_ANSWERED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_BOX0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV2 = 3'd5;

    localparam logic [ROW_W-1:0] BOX_ROW0_RST = 60'd1024;
    localparam logic [ROW_W-1:0] BOX_ROW1_RST = 60'd1024 << 20;
    localparam logic [ROW_W-1:0] BOX_ROW2_RST = 60'd1024 << 40;
    localparam logic [ROW_W-1:0] INV_ROW0_RST = 60'd262144;
    localparam logic [ROW_W-1:0] INV_ROW1_RST = 60'd262144 << 20;
    localparam logic [ROW_W-1:0] INV_ROW2_RST = 60'd262144 << 40;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FRAC_MUL,
        S_FRAC_ACC,
        S_STORE,
        S_SCAN,
        S_SQRT,
        S_DONE
    } pnn_state_t;

endpackage

>>> rtl/pnn_ram.sv
// ----------------------------------------------------------------------------
// pnn_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pnn_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/pnn_isqrt.sv
// ----------------------------------------------------------------------------
// pnn_isqrt: iterative integer square root
// Digit-by-digit method, one result bit per cycle.
// ----------------------------------------------------------------------------
module pnn_isqrt #(
    parameter int W = 58
) (
    input  logic             clk,
    input  logic             rstn,
    input  logic             start,
    input  logic [W-1:0]     radicand,
    output logic             done,
    output logic [W/2-1:0]   root
);

    logic [W-1:0] x_reg, x_next;
    logic [W-1:0] res_reg, res_next;
    logic [W-1:0] bit_reg, bit_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [W:0]   trial;

    always_comb begin
        trial     = {1'b0, res_reg} + {1'b0, bit_reg};
        x_next    = x_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = radicand;
            res_next  = '0;
            bit_next  = W'(1) << (W - 2);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if ({1'b0, x_reg} >= trial) begin
                x_next   = x_reg - W'(trial);
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg   <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[W/2-1:0];

endmodule

>>> rtl/periodic_nearest_neighbor_core.sv
// ----------------------------------------------------------------------------
// periodic_nearest_neighbor_core: minimum-image nearest-neighbour search
// Stores reference points as fractional coordinates in RAM and answers
// queries with the closest point under periodic boundaries.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_mode, s_point_x/y/z
//   m_       out  m_valid/m_ready    m_status, m_nearest_index, m_distance
//   cfg_     in   cfg_wr_en          cfg_index, cfg_wr_data
//
// Flow of an item, from accept to the next accept with the output free:
// clear, dropped store and empty query go straight to the result. Store:
// three 3-multiplier passes for the fractional transform, then the RAM write.
// Query: the same transform, then the scan reads one RAM entry a cycle over the
// N stored points through a 6-stage pipeline, then the root of the best is taken.
// Reset is synchronous; stored points are undefined until written.
// One item in flight; a finished beat waits in the output register and the
// next item is taken meanwhile.
// ----------------------------------------------------------------------------
module periodic_nearest_neighbor_core import pnn_pkg::*; #(
    parameter int MAX_REFS    = MAX_REFS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [ROW_W-1:0]              cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_mode,
    input  logic signed [COORD_WIDTH-1:0] s_point_x,
    input  logic signed [COORD_WIDTH-1:0] s_point_y,
    input  logic signed [COORD_WIDTH-1:0] s_point_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [STATUS_W-1:0]           m_status,
    output logic [INDEX_W-1:0]            m_nearest_index,
    output logic [DIST_W-1:0]             m_distance
);

    localparam int AW   = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int CW   = $clog2(MAX_REFS + 1);
    localparam int MW   = 3 * FRAC_W;
    localparam int PW   = COORD_WIDTH + ENTRY_W;
    localparam int SW   = PW + 2;
    localparam int WW   = 17;              // wrapped fraction, Q16
    localparam int QPW  = WW + ENTRY_W;
    localparam int QSW  = QPW + 2;
    localparam int CMW  = 28;              // |real coordinate|, Q16
    localparam int SQPW = 2 * CMW;
    localparam int RTW  = SQ_W / 2;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REFS);

    // ---------------- configuration ----------------
    logic [ROW_W-1:0] box_reg [3];
    logic [ROW_W-1:0] inv_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg[0] <= BOX_ROW0_RST;
            box_reg[1] <= BOX_ROW1_RST;
            box_reg[2] <= BOX_ROW2_RST;
            inv_reg[0] <= INV_ROW0_RST;
            inv_reg[1] <= INV_ROW1_RST;
            inv_reg[2] <= INV_ROW2_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BOX0: box_reg[0] <= cfg_wr_data;
                REG_BOX1: box_reg[1] <= cfg_wr_data;
                REG_BOX2: box_reg[2] <= cfg_wr_data;
                REG_INV0: inv_reg[0] <= cfg_wr_data;
                REG_INV1: inv_reg[1] <= cfg_wr_data;
                REG_INV2: inv_reg[2] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // ---------------- control ----------------
    pnn_state_t state_reg, state_next;

    logic [1:0]                    mode_reg;
    logic signed [COORD_WIDTH-1:0] p_reg [3];
    logic [CW-1:0]                 count_reg;
    logic [1:0]                    ci_reg;
    logic [CW-1:0]                 issue_reg;
    logic                          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic                          sqrt_done;
    logic [RTW-1:0]                sqrt_root;

    logic s_fire, scan_issue, scan_end, ram_we, sqrt_start, out_load, frac_last;

    assign s_fire    = s_valid && s_ready;
    assign frac_last = (ci_reg == 2'd2);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_mode == MODE_CLEAR) begin
                        state_next = S_DONE;
                    end else if (s_mode == MODE_STORE) begin
                        state_next = (count_reg == MAX_CNT) ? S_DONE : S_FRAC_MUL;
                    end else begin
                        state_next = (count_reg == '0) ? S_DONE : S_FRAC_MUL;
                    end
                end
            end
            S_FRAC_MUL: state_next = S_FRAC_ACC;
            S_FRAC_ACC: begin
                if (!frac_last) begin
                    state_next = S_FRAC_MUL;
                end else if (mode_reg == MODE_STORE) begin
                    state_next = S_STORE;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_STORE: state_next = S_DONE;
            S_SCAN: begin
                if (scan_end) state_next = S_SQRT;
            end
            S_SQRT: begin
                if (sqrt_done) state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid || m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == S_IDLE);
        ram_we     = (state_reg == S_STORE);
        scan_issue = (state_reg == S_SCAN) && (issue_reg != count_reg);
        scan_end   = (state_reg == S_SCAN) && (issue_reg == count_reg) &&
                     !(v1_reg || v2_reg || v3_reg || v4_reg || v5_reg || v6_reg);
        sqrt_start = scan_end;
        out_load   = (state_reg == S_DONE) && (!m_valid || m_ready);
    end

    // ---------------- fractional transform ----------------
    logic signed [PW-1:0]     fprod_reg [3];
    logic signed [FRAC_W-1:0] f_reg [3];
    logic signed [SW-1:0]     fsum;
    logic                     fneg;
    logic [SW-1:0]            fmag, frnd;
    logic signed [SW:0]       fval;
    logic signed [FRAC_W-1:0] fsat;

    always_comb begin
        fsum = SW'(fprod_reg[0]) + SW'(fprod_reg[1]) + SW'(fprod_reg[2]);
        fneg = fsum[SW-1];
        fmag = fneg ? SW'(-fsum) : SW'(fsum);
        frnd = (fmag + SW'(2048)) >> 12;
        fval = fneg ? -$signed({1'b0, frnd}) : $signed({1'b0, frnd});
        if (fval > (SW + 1)'(FRAC_MAX)) begin
            fsat = FRAC_W'(FRAC_MAX);
        end else if (fval < (SW + 1)'(FRAC_MIN)) begin
            fsat = FRAC_W'(FRAC_MIN);
        end else begin
            fsat = fval[FRAC_W-1:0];
        end
    end

    // ---------------- reference RAM ----------------
    logic [MW-1:0] rdata;

    pnn_ram #(
        .WIDTH(MW),
        .DEPTH(MAX_REFS)
    ) u_ref_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(count_reg[AW-1:0]),
        .wdata({f_reg[2], f_reg[1], f_reg[0]}),
        .raddr(issue_reg[AW-1:0]),
        .rdata(rdata)
    );

    // ---------------- scan pipeline ----------------
    logic signed [WW-1:0]  w_comb [3];
    logic signed [WW-1:0]  w_reg [3];
    logic signed [QPW-1:0] prod_reg [3][3];
    logic [CMW-1:0]        cmag_comb [3];
    logic [CMW-1:0]        cmag_reg [3];
    logic [SQPW-1:0]       sqp_reg [3];
    logic [SQ_W-1:0]       sq_reg, best_reg;
    logic [AW-1:0]         idx1_reg, idx2_reg, idx3_reg, idx4_reg, idx5_reg, idx6_reg;
    logic [AW-1:0]         best_idx_reg;

    always_comb begin
        logic signed [FRAC_W:0] d;
        logic [15:0]            u;
        logic signed [QSW-1:0]  qsum;
        logic [QSW-1:0]         qmag;
        for (int i = 0; i < 3; i++) begin
            d = (FRAC_W + 1)'(f_reg[i]) -
                (FRAC_W + 1)'($signed(rdata[FRAC_W*i +: FRAC_W]));
            u = d[15:0];
            // exact half wraps towards the opposite sign of d
            if (u == 16'h8000 && d[FRAC_W]) begin
                w_comb[i] = WW'(32768);
            end else begin
                w_comb[i] = $signed({u[15], u});
            end
        end
        for (int i = 0; i < 3; i++) begin
            qsum = QSW'(prod_reg[0][i]) + QSW'(prod_reg[1][i]) + QSW'(prod_reg[2][i]);
            qmag = qsum[QSW-1] ? QSW'(-qsum) : QSW'(qsum);
            cmag_comb[i] = CMW'((qmag + QSW'(512)) >> 10);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            v1_reg <= scan_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
        idx1_reg <= issue_reg[AW-1:0];
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;
        idx5_reg <= idx4_reg;
        idx6_reg <= idx5_reg;
        for (int i = 0; i < 3; i++) begin
            w_reg[i]    <= w_comb[i];
            cmag_reg[i] <= cmag_comb[i];
            sqp_reg[i]  <= cmag_reg[i] * cmag_reg[i];
            for (int j = 0; j < 3; j++) begin
                prod_reg[j][i] <= w_reg[j] * $signed(box_reg[j][ENTRY_W*i +: ENTRY_W]);
            end
        end
        sq_reg <= SQ_W'(sqp_reg[0]) + SQ_W'(sqp_reg[1]) + SQ_W'(sqp_reg[2]);
        if (v6_reg && (idx6_reg == '0 || sq_reg < best_reg)) begin
            best_reg     <= sq_reg;
            best_idx_reg <= idx6_reg;
        end
    end

    pnn_isqrt #(
        .W(SQ_W)
    ) u_isqrt (
        .clk     (aclk),
        .rstn    (aresetn),
        .start   (sqrt_start),
        .radicand(best_reg),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    // ---------------- item datapath ----------------
    logic [STATUS_W-1:0] res_status_reg;
    logic [AW-1:0]       res_idx_reg;
    logic [DIST_W-1:0]   res_dist_reg;
    logic [RTW-7:0]      root_q10;

    assign root_q10 = sqrt_root[RTW-1:6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            issue_reg <= '0;
            ci_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (s_fire && s_mode == MODE_CLEAR) begin
                count_reg <= '0;
            end else if (ram_we) begin
                count_reg <= count_reg + CW'(1);
            end
            if (state_reg == S_FRAC_ACC) begin
                ci_reg <= frac_last ? 2'd0 : ci_reg + 2'd1;
            end
            if (state_reg == S_FRAC_ACC && frac_last) begin
                issue_reg <= '0;
            end else if (scan_issue) begin
                issue_reg <= issue_reg + CW'(1);
            end
        end
        if (s_fire) begin
            mode_reg       <= s_mode;
            p_reg[0]       <= s_point_x;
            p_reg[1]       <= s_point_y;
            p_reg[2]       <= s_point_z;
            res_idx_reg    <= '0;
            res_dist_reg   <= '0;
            if (s_mode == MODE_CLEAR) begin
                res_status_reg <= STAT_CLEARED;
            end else if (s_mode == MODE_STORE) begin
                res_status_reg <= STAT_DROPPED;
            end else begin
                res_status_reg <= STAT_EMPTY;
            end
        end
        if (state_reg == S_FRAC_MUL) begin
            for (int j = 0; j < 3; j++) begin
                fprod_reg[j] <= p_reg[j] * $signed(inv_reg[j][ENTRY_W*ci_reg +: ENTRY_W]);
            end
        end
        if (state_reg == S_FRAC_ACC) begin
            f_reg[ci_reg] <= fsat;
        end
        if (ram_we) begin
            res_status_reg <= STAT_STORED;
        end
        if (state_reg == S_SQRT && sqrt_done) begin
            res_status_reg <= STAT_ANSWERED;
            res_idx_reg    <= best_idx_reg;
            res_dist_reg   <= (root_q10 > (RTW - 6)'(2 ** DIST_W - 1)) ?
                              {DIST_W{1'b1}} : DIST_W'(root_q10);
        end
    end

    // ---------------- output register ----------------
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [INDEX_W-1:0]  m_index_reg;
    logic [DIST_W-1:0]   m_dist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_index_reg  <= INDEX_W'(res_idx_reg);
            m_dist_reg   <= res_dist_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_nearest_index = m_index_reg;
    assign m_distance      = m_dist_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_CNT)
        else $error("reference count beyond capacity");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> !ram_we)
        else $error("RAM write during scan");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_mode == MODE_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty the set");

    a_zero_unless_answered: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STAT_ANSWERED) |->
        (m_nearest_index == '0 && m_distance == '0))
        else $error("index or distance set on a non-answer beat");

    a_scan_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_start |-> !v6_reg && (issue_reg == count_reg))
        else $error("root started before scan drained");

endmodule
